@@ hdl/hmp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmp_pkg
// Shared constants and Q8.24 saturating arithmetic for the Heston path step.
// ----------------------------------------------------------------------------
package hmp_pkg;

    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 24;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int ROOT_W   = 28;             // root of a 56-bit radicand
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 31;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_KAPPA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THETA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_XI     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RHO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RHOBAR = 3'd4;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t FX_ONE     = 32'sh0100_0000;
    localparam word_t FX_HALF    = 32'sh0080_0000;
    localparam word_t FX_QUARTER = 32'sh0040_0000;
    localparam word_t WORD_MAX   = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN   = 32'sh8000_0000;

    // saturating sum
    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        return s[WORD_W-1:0];
    endfunction

    // saturating difference
    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        return s[WORD_W-1:0];
    endfunction

    // round a product magnitude to nearest (ties away), apply sign, saturate
    function automatic word_t round_sat(input logic [PROD_W-1:0] p, input logic neg);
        logic [PROD_W-1:0]        r;
        logic [PROD_W-FRAC_W-1:0] q;
        r = p + (PROD_W'(1) << (FRAC_W - 1));
        q = r[PROD_W-1:FRAC_W];
        if (neg) begin
            if (q > (PROD_W-FRAC_W)'(64'h8000_0000))
                q = (PROD_W-FRAC_W)'(64'h8000_0000);
            return -word_t'(q[WORD_W-1:0]);
        end
        if (q > (PROD_W-FRAC_W)'(64'h7FFF_FFFF))
            q = (PROD_W-FRAC_W)'(64'h7FFF_FFFF);
        return word_t'(q[WORD_W-1:0]);
    endfunction

endpackage

@@ hdl/hmp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmp_in_if
// Input channel: one path state and two normal draws per item.
// ----------------------------------------------------------------------------
interface hmp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] log_ratio;
    logic [31:0] variance;
    logic [30:0] step_length;
    logic [31:0] normal_first;
    logic [31:0] normal_second;

    modport source (output valid, log_ratio, variance, step_length,
                    normal_first, normal_second, input ready);
    modport sink   (input valid, log_ratio, variance, step_length,
                    normal_first, normal_second, output ready);
endinterface

@@ hdl/hmp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmp_out_if
// Output channel: advanced path state, one item per input item.
// ----------------------------------------------------------------------------
interface hmp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_log_ratio;
    logic [30:0] next_variance;

    modport source (output valid, next_log_ratio, next_variance, input ready);
    modport sink   (input valid, next_log_ratio, next_variance, output ready);
endinterface

@@ hdl/heston_milstein_path_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heston_milstein_path_step
// One Heston path step, Milstein variance update with full truncation, Q8.24.
// ----------------------------------------------------------------------------
// Throughput: one item per clock while the output is not stalled; the 28-stage root pipelines set the depth.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults (rho_bar = 1.0).
module heston_milstein_path_step
(
    input  logic                              clk,
    input  logic                              rst_n,
    hmp_in_if.sink                            item_in,
    hmp_out_if.source                         item_out,
    input  logic                              cfg_en,
    input  logic [hmp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hmp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LAT = 36;

    // configuration registers
    logic [30:0] kappa_reg;
    logic [30:0] theta_reg;
    logic [30:0] xi_reg;
    logic [25:0] rho_reg;
    logic [24:0] rhobar_reg;

    hmp_pkg::word_t kappa;
    hmp_pkg::word_t theta;
    hmp_pkg::word_t xi;
    hmp_pkg::word_t rho;
    hmp_pkg::word_t rhobar;

    logic           adv;
    logic [LAT:0]   vld_reg;

    hmp_pkg::word_t lr0_reg, v0_reg, z1_0_reg, z2_0_reg, dt0_reg;
    hmp_pkg::word_t dt_d   [1:7];
    hmp_pkg::word_t lr_d   [1:4];
    hmp_pkg::word_t v_d    [1:5];
    hmp_pkg::word_t z1_d   [1:30];
    hmp_pkg::word_t lra_d  [1:27];
    hmp_pkg::word_t wv_d   [1:29];
    hmp_pkg::word_t v1_d   [1:28];
    hmp_pkg::word_t mil_d  [1:25];
    hmp_pkg::word_t sdt_d  [1:2];
    hmp_pkg::word_t lr2_d  [1:3];

    hmp_pkg::word_t rz1, rbz2, wv_reg;
    hmp_pkg::word_t vh, vhdt, lra_reg;
    hmp_pkg::word_t tv_reg, ktv, kdt, v1_reg;
    hmp_pkg::word_t ww, wwdt, md_reg, qx, qxx, mil;
    logic [hmp_pkg::ROOT_W-1:0] sv_root, sdt_root;
    hmp_pkg::word_t sv, sdt;
    hmp_pkg::word_t sd, xsv, dz, xsvs, dv;
    hmp_pkg::word_t lr2_reg, va_reg, vb_reg, vb_sum;

    assign kappa  = hmp_pkg::word_t'({1'b0, kappa_reg});
    assign theta  = hmp_pkg::word_t'({1'b0, theta_reg});
    assign xi     = hmp_pkg::word_t'({1'b0, xi_reg});
    assign rho    = hmp_pkg::word_t'({{6{rho_reg[25]}}, rho_reg});
    assign rhobar = hmp_pkg::word_t'({7'd0, rhobar_reg});

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kappa_reg  <= '0;
            theta_reg  <= '0;
            xi_reg     <= '0;
            rho_reg    <= '0;
            rhobar_reg <= 25'(hmp_pkg::FX_ONE);
        end
        else if (cfg_en)
        begin
            case (cfg_index)
                hmp_pkg::REG_KAPPA:  kappa_reg  <= cfg_data;
                hmp_pkg::REG_THETA:  theta_reg  <= cfg_data;
                hmp_pkg::REG_XI:     xi_reg     <= cfg_data;
                hmp_pkg::REG_RHO:    rho_reg    <= cfg_data[25:0];
                hmp_pkg::REG_RHOBAR: rhobar_reg <= cfg_data[24:0];
                default: ;
            endcase
        end
    end

    // global advance: the pipeline moves unless the result is held
    assign adv           = !vld_reg[LAT] || item_out.ready;
    assign item_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-1:0], item_in.valid};
    end

    // input stage, variance floored at zero
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lr0_reg  <= item_in.log_ratio;
            v0_reg   <= item_in.variance[31] ? '0 : item_in.variance;
            dt0_reg  <= hmp_pkg::word_t'({1'b0, item_in.step_length});
            z1_0_reg <= item_in.normal_first;
            z2_0_reg <= item_in.normal_second;
        end
    end

    // alignment delay lines
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dt_d[1]  <= dt0_reg;
            lr_d[1]  <= lr0_reg;
            v_d[1]   <= v0_reg;
            z1_d[1]  <= z1_0_reg;
            lra_d[1] <= lra_reg;
            wv_d[1]  <= wv_reg;
            v1_d[1]  <= v1_reg;
            mil_d[1] <= mil;
            sdt_d[1] <= sdt;
            lr2_d[1] <= lr2_reg;
            for (int i = 2; i <= 7; i++)  dt_d[i]  <= dt_d[i-1];
            for (int i = 2; i <= 4; i++)  lr_d[i]  <= lr_d[i-1];
            for (int i = 2; i <= 5; i++)  v_d[i]   <= v_d[i-1];
            for (int i = 2; i <= 30; i++) z1_d[i]  <= z1_d[i-1];
            for (int i = 2; i <= 27; i++) lra_d[i] <= lra_d[i-1];
            for (int i = 2; i <= 29; i++) wv_d[i]  <= wv_d[i-1];
            for (int i = 2; i <= 28; i++) v1_d[i]  <= v1_d[i-1];
            for (int i = 2; i <= 25; i++) mil_d[i] <= mil_d[i-1];
            sdt_d[2] <= sdt_d[1];
            for (int i = 2; i <= 3; i++)  lr2_d[i] <= lr2_d[i-1];
        end
    end

    // correlated normal: wv = rho*z1 + rho_bar*z2
    hmp_fmul u_rz1  (.clk(clk), .en(adv), .a(rho),    .b(z1_0_reg), .y(rz1));
    hmp_fmul u_rbz2 (.clk(clk), .en(adv), .a(rhobar), .b(z2_0_reg), .y(rbz2));

    // log drift: lr - (v/2)*dt
    hmp_fmul u_vh   (.clk(clk), .en(adv), .a(v0_reg), .b(hmp_pkg::FX_HALF), .y(vh));
    hmp_fmul u_vhdt (.clk(clk), .en(adv), .a(vh),     .b(dt_d[2]), .y(vhdt));

    // mean reversion: v + kappa*(theta - v)*dt
    hmp_fmul u_ktv  (.clk(clk), .en(adv), .a(kappa), .b(tv_reg),  .y(ktv));
    hmp_fmul u_kdt  (.clk(clk), .en(adv), .a(ktv),   .b(dt_d[3]), .y(kdt));

    // Milstein correction: (xi^2/4) * (wv^2*dt - dt)
    hmp_fmul u_ww   (.clk(clk), .en(adv), .a(wv_reg), .b(wv_reg),  .y(ww));
    hmp_fmul u_wwdt (.clk(clk), .en(adv), .a(ww),     .b(dt_d[5]), .y(wwdt));
    hmp_fmul u_qx   (.clk(clk), .en(1'b1), .a(hmp_pkg::FX_QUARTER), .b(xi), .y(qx));
    hmp_fmul u_qxx  (.clk(clk), .en(1'b1), .a(qx),     .b(xi),      .y(qxx));
    hmp_fmul u_mil  (.clk(clk), .en(adv),  .a(md_reg), .b(qxx),     .y(mil));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wv_reg  <= hmp_pkg::sat_add(rz1, rbz2);
            lra_reg <= hmp_pkg::sat_sub(lr_d[4], vhdt);
            tv_reg  <= hmp_pkg::sat_sub(theta, v0_reg);
            v1_reg  <= hmp_pkg::sat_add(v_d[5], kdt);
            md_reg  <= hmp_pkg::sat_sub(wwdt, dt_d[7]);
        end
    end

    // square roots of v and dt
    hmp_sqrt u_sqrt_v  (.clk(clk), .en(adv),
                        .radicand({v0_reg[30:0], 24'd0, 1'b0} >> 1),
                        .root(sv_root));
    hmp_sqrt u_sqrt_dt (.clk(clk), .en(adv),
                        .radicand({dt0_reg[30:0], 24'd0, 1'b0} >> 1),
                        .root(sdt_root));

    assign sv  = hmp_pkg::word_t'({4'd0, sv_root});
    assign sdt = hmp_pkg::word_t'({4'd0, sdt_root});

    // diffusion products
    hmp_fmul u_sd   (.clk(clk), .en(adv), .a(sv),  .b(sdt),      .y(sd));
    hmp_fmul u_xsv  (.clk(clk), .en(adv), .a(xi),  .b(sv),       .y(xsv));
    hmp_fmul u_dz   (.clk(clk), .en(adv), .a(sd),  .b(z1_d[30]), .y(dz));
    hmp_fmul u_xsvs (.clk(clk), .en(adv), .a(xsv), .b(sdt_d[2]), .y(xsvs));
    hmp_fmul u_dv   (.clk(clk), .en(adv), .a(xsvs), .b(wv_d[29]), .y(dv));

    // final sums, variance floored at zero
    assign vb_sum = hmp_pkg::sat_add(va_reg, mil_d[25]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lr2_reg <= hmp_pkg::sat_add(lra_d[27], dz);
            va_reg  <= hmp_pkg::sat_add(v1_d[28], dv);
            vb_reg  <= vb_sum[31] ? '0 : vb_sum;
        end
    end

    assign item_out.valid          = vld_reg[LAT];
    assign item_out.next_log_ratio = lr2_d[3];
    assign item_out.next_variance  = vb_reg[30:0];

`ifndef SYNTHESIS
    // accepted item enters the first stage
    a_enter : assert property (@(posedge clk) disable iff (!rst_n)
        item_in.valid && item_in.ready |=> vld_reg[0])
        else $error("accepted item missing from input stage");

    // a held result freezes every valid bit
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    // variance result never negative
    a_floor : assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[LAT] |-> !vb_reg[31])
        else $error("negative variance reached output");
`endif

endmodule

@@ hdl/hmp_fmul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmp_fmul
// Two-stage Q8.24 multiplier: magnitude product, then round and saturate.
// ----------------------------------------------------------------------------
module hmp_fmul
(
    input  logic          clk,
    input  logic          en,
    input  hmp_pkg::word_t a,
    input  hmp_pkg::word_t b,
    output hmp_pkg::word_t y
);

    logic [hmp_pkg::WORD_W-1:0] mag_a;
    logic [hmp_pkg::WORD_W-1:0] mag_b;
    logic [hmp_pkg::PROD_W-1:0] prod_reg;
    logic                       neg_reg;
    hmp_pkg::word_t             y_reg;

    assign mag_a = a[hmp_pkg::WORD_W-1] ? -a : a;
    assign mag_b = b[hmp_pkg::WORD_W-1] ? -b : b;

    // stage 1: unsigned 32x32 product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= hmp_pkg::PROD_W'(mag_a) * hmp_pkg::PROD_W'(mag_b);
            neg_reg  <= a[hmp_pkg::WORD_W-1] ^ b[hmp_pkg::WORD_W-1];
        end
    end

    // stage 2: round, sign, saturate
    always_ff @(posedge clk)
    begin
        if (en)
            y_reg <= hmp_pkg::round_sat(prod_reg, neg_reg);
    end

    assign y = y_reg;

endmodule

@@ hdl/hmp_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmp_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module hmp_sqrt
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [hmp_pkg::RAD_W-1:0]   radicand,
    output logic [hmp_pkg::ROOT_W-1:0]  root
);

    localparam int N     = hmp_pkg::ROOT_W;
    localparam int REM_W = hmp_pkg::ROOT_W + 2;

    logic [hmp_pkg::RAD_W-1:0] rad_reg  [0:N-1];
    logic [REM_W-1:0]          rem_reg  [0:N-1];
    logic [N-1:0]              root_reg [0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic [hmp_pkg::RAD_W-1:0] src_rad;
            logic [REM_W-1:0]          src_rem;
            logic [N-1:0]              src_root;
            logic [REM_W+1:0]          t_rem;
            logic [REM_W+1:0]          trial;
            logic [hmp_pkg::RAD_W-1:0] rad_next;
            logic [REM_W-1:0]          rem_next;
            logic [N-1:0]              root_next;

            // previous stage, or the new radicand at the head
            if (k == 0)
            begin : g_head
                assign src_rad  = radicand;
                assign src_rem  = '0;
                assign src_root = '0;
            end
            else
            begin : g_tail
                assign src_rad  = rad_reg[k-1];
                assign src_rem  = rem_reg[k-1];
                assign src_root = root_reg[k-1];
            end

            // bring down two radicand bits, try the next root bit
            always_comb
            begin
                t_rem    = {src_rem, src_rad[hmp_pkg::RAD_W-1 -: 2]};
                trial    = (REM_W+2)'({src_root, 2'b01});
                rad_next = src_rad << 2;
                if (t_rem >= trial)
                begin
                    rem_next  = REM_W'(t_rem - trial);
                    root_next = {src_root[N-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = t_rem[REM_W-1:0];
                    root_next = {src_root[N-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[k]  <= rad_next;
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[N-1];

endmodule
